@@ rtl/ipm_pkg.sv @@
`default_nettype none
package ipm_pkg;

    localparam int ADR_W         = 32;
    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int LEN_W         = 6;
    localparam int CC_W          = 16;
    localparam int ST_W          = 3;
    localparam int MRG_W         = 6;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    // result status codes
    localparam logic [ST_W-1:0] ST_NEW     = 3'd0;
    localparam logic [ST_W-1:0] ST_PRESENT = 3'd1;
    localparam logic [ST_W-1:0] ST_CONFL   = 3'd2;
    localparam logic [ST_W-1:0] ST_BADLEN  = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL    = 3'd4;
    localparam logic [ST_W-1:0] ST_READ    = 3'd5;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    // sweep kinds
    localparam logic MODE_SIB  = 1'b0;
    localparam logic MODE_FIND = 1'b1;

    typedef struct packed {
        logic             valid;
        logic [LEN_W-1:0] len;
        logic [ADR_W-1:0] addr;
        logic [CC_W-1:0]  cc;
    } t_entry;

    typedef struct packed {
        logic            load;
        logic            clear_wr;
        logic            rd_slot;
        logic            sweep_start;
        logic            sweep_mode;
        logic            sweep_run;
        logic            merge;
        logic            store;
        logic            out_load;
        logic [ST_W-1:0] out_status;
    } t_cmd;

    typedef struct packed {
        logic op_read;
        logic len_bad;
        logic len_zero;
        logic len_one;
        logic hit;
        logic same;
        logic done;
        logic free_any;
        logic clr_last;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

@@ rtl/ipm_ctrl.sv @@
`default_nettype none
module ipm_ctrl (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    output logic                     o_in_stall,
    input  wire ipm_pkg::t_stat      i_stat,
    output ipm_pkg::t_cmd            o_cmd
);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_DEC  = 3'd2;
    localparam logic [2:0] S_SIB  = 3'd3;
    localparam logic [2:0] S_FND  = 3'd4;
    localparam logic [2:0] S_RDW  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0]              r_state, n_state;
    logic [ipm_pkg::ST_W-1:0] r_st, n_st;

    // state and latched status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_st    <= ipm_pkg::ST_NEW;
        end else begin
            r_state <= n_state;
            r_st    <= n_st;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_st    = r_st;
        o_cmd   = '0;
        case (r_state)
            S_CLR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                if (i_stat.op_read) begin
                    o_cmd.rd_slot = 1'b1;
                    n_state       = S_RDW;
                end else if (i_stat.len_bad) begin
                    n_st    = ipm_pkg::ST_BADLEN;
                    n_state = S_FIN;
                end else if (i_stat.len_zero) begin
                    o_cmd.sweep_start = 1'b1;
                    o_cmd.sweep_mode  = ipm_pkg::MODE_FIND;
                    n_state           = S_FND;
                end else begin
                    o_cmd.sweep_start = 1'b1;
                    o_cmd.sweep_mode  = ipm_pkg::MODE_SIB;
                    n_state           = S_SIB;
                end
            end
            S_SIB: begin
                o_cmd.sweep_run = 1'b1;
                if (i_stat.hit && i_stat.same) begin
                    // absorb sibling, rescan one level up
                    o_cmd.merge       = 1'b1;
                    o_cmd.sweep_start = 1'b1;
                    if (i_stat.len_one) begin
                        o_cmd.sweep_mode = ipm_pkg::MODE_FIND;
                        n_state          = S_FND;
                    end else begin
                        o_cmd.sweep_mode = ipm_pkg::MODE_SIB;
                    end
                end else if (i_stat.hit || i_stat.done) begin
                    o_cmd.sweep_start = 1'b1;
                    o_cmd.sweep_mode  = ipm_pkg::MODE_FIND;
                    n_state           = S_FND;
                end
            end
            S_FND: begin
                o_cmd.sweep_run = 1'b1;
                if (i_stat.hit) begin
                    n_st    = i_stat.same ? ipm_pkg::ST_PRESENT : ipm_pkg::ST_CONFL;
                    n_state = S_FIN;
                end else if (i_stat.done) begin
                    n_st    = i_stat.free_any ? ipm_pkg::ST_NEW : ipm_pkg::ST_FULL;
                    n_state = S_FIN;
                end
            end
            S_RDW: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = ipm_pkg::ST_READ;
                    n_state          = S_IDLE;
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = r_st;
                    o_cmd.store      = (r_st == ipm_pkg::ST_NEW);
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/ipm_dp.sv @@
`default_nettype none
module ipm_dp (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire ipm_pkg::t_cmd                 i_cmd,
    output ipm_pkg::t_stat                     o_stat,
    input  wire                                i_opcode,
    input  wire [ipm_pkg::ADR_W-1:0]           i_address,
    input  wire [ipm_pkg::LEN_W-1:0]           i_prefix_len,
    input  wire [ipm_pkg::CC_W-1:0]            i_country,
    input  wire [ipm_pkg::IDX_W-1:0]           i_slot,
    input  wire                                i_out_stall,
    output logic                               o_out_valid,
    output logic [ipm_pkg::ST_W-1:0]           o_status,
    output logic [ipm_pkg::LEN_W-1:0]          o_final_len,
    output logic [ipm_pkg::ADR_W-1:0]          o_final_address,
    output logic [ipm_pkg::MRG_W-1:0]          o_merge_count,
    output logic                               o_entry_valid,
    output logic [ipm_pkg::LEN_W-1:0]          o_entry_len,
    output logic [ipm_pkg::ADR_W-1:0]          o_entry_address,
    output logic [ipm_pkg::CC_W-1:0]           o_entry_country
);

    localparam logic [ipm_pkg::LEN_W-1:0] FULL_LEN = ipm_pkg::LEN_W'(ipm_pkg::ADR_W);
    localparam logic [ipm_pkg::ADR_W-1:0] ONES = '1;
    localparam logic [ipm_pkg::ADR_W-1:0] ONE  = ipm_pkg::ADR_W'(1);

    ipm_pkg::t_entry mem [ipm_pkg::TABLE_ENTRIES];
    ipm_pkg::t_entry r_rd;

    // current item
    logic                          r_op;
    logic [ipm_pkg::LEN_W-1:0]     r_len;
    logic [ipm_pkg::ADR_W-1:0]     r_addr;
    logic [ipm_pkg::CC_W-1:0]      r_cc;
    logic [ipm_pkg::IDX_W-1:0]     r_slot;
    logic [ipm_pkg::MRG_W-1:0]     r_merges;

    // sweep state
    logic                          r_mode;
    logic [ipm_pkg::IDX_W-1:0]     r_ridx;
    logic                          r_idone;
    logic                          r_cv;
    logic [ipm_pkg::IDX_W-1:0]     r_cidx;
    logic                          r_free_found;
    logic [ipm_pkg::IDX_W-1:0]     r_free_idx;

    logic                          r_ovalid;

    logic [ipm_pkg::ADR_W-1:0]     bit_sel, key_addr, in_mask;
    logic                          issue, match, rd_en, we;
    logic [ipm_pkg::IDX_W-1:0]     raddr, waddr;
    ipm_pkg::t_entry               wdata;

    assign bit_sel  = ONE << (FULL_LEN - r_len);
    assign key_addr = (r_mode == ipm_pkg::MODE_SIB) ? (r_addr ^ bit_sel) : r_addr;
    assign in_mask  = ONES << (FULL_LEN - i_prefix_len);
    assign issue    = i_cmd.sweep_run && !i_cmd.sweep_start && !r_idone;
    assign match    = r_cv && r_rd.valid && (r_rd.len == r_len) && (r_rd.addr == key_addr);

    // status to controller
    always_comb begin
        o_stat.op_read  = (r_op == ipm_pkg::OP_READ);
        o_stat.len_bad  = (r_len > FULL_LEN);
        o_stat.len_zero = (r_len == '0);
        o_stat.len_one  = (r_len == ipm_pkg::LEN_W'(1));
        o_stat.hit      = match;
        o_stat.same     = (r_rd.cc == r_cc);
        o_stat.done     = r_cv && !match && (r_cidx == ipm_pkg::LAST_IDX);
        o_stat.free_any = r_free_found || (r_cv && !r_rd.valid);
        o_stat.clr_last = (r_ridx == ipm_pkg::LAST_IDX);
        o_stat.out_free = !r_ovalid || !i_out_stall;
    end

    // memory port selection
    always_comb begin
        rd_en = issue || i_cmd.rd_slot;
        raddr = i_cmd.rd_slot ? r_slot : r_ridx;
        we    = i_cmd.clear_wr || i_cmd.merge || i_cmd.store;
        waddr = r_ridx;
        wdata = '0;
        if (i_cmd.merge) begin
            waddr       = r_cidx;
            wdata       = r_rd;
            wdata.valid = 1'b0;
        end else if (i_cmd.store) begin
            waddr = r_free_idx;
            wdata = '{valid: 1'b1, len: r_len, addr: r_addr, cc: r_cc};
        end
    end

    // table memory
    always_ff @(posedge i_clk) begin
        if (we) mem[waddr] <= wdata;
        if (rd_en) r_rd <= mem[raddr];
    end

    // item registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_opcode;
            r_len    <= i_prefix_len;
            r_addr   <= i_address & in_mask;
            r_cc     <= i_country;
            r_slot   <= i_slot;
            r_merges <= '0;
        end else if (i_cmd.merge) begin
            r_addr   <= r_addr & ~bit_sel;
            r_len    <= r_len - ipm_pkg::LEN_W'(1);
            r_merges <= r_merges + ipm_pkg::MRG_W'(1);
        end
    end

    // sweep counter and compare stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ridx       <= '0;
            r_idone      <= 1'b0;
            r_cv         <= 1'b0;
            r_free_found <= 1'b0;
            r_mode       <= ipm_pkg::MODE_SIB;
        end else if (i_cmd.sweep_start) begin
            r_ridx       <= '0;
            r_idone      <= 1'b0;
            r_cv         <= 1'b0;
            r_free_found <= 1'b0;
            r_mode       <= i_cmd.sweep_mode;
        end else begin
            r_cv <= issue;
            if (issue || i_cmd.clear_wr) r_ridx <= r_ridx + ipm_pkg::IDX_W'(1);
            if (issue && r_ridx == ipm_pkg::LAST_IDX) r_idone <= 1'b1;
            if (r_cv && !r_rd.valid && !r_free_found) r_free_found <= 1'b1;
        end
    end

    // first free slot and compare index
    always_ff @(posedge i_clk) begin
        if (issue) r_cidx <= r_ridx;
        if (!i_cmd.sweep_start && r_cv && !r_rd.valid && !r_free_found) r_free_idx <= r_cidx;
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_status        <= i_cmd.out_status;
            o_final_len     <= '0;
            o_final_address <= '0;
            o_merge_count   <= '0;
            o_entry_valid   <= 1'b0;
            o_entry_len     <= '0;
            o_entry_address <= '0;
            o_entry_country <= '0;
            if (i_cmd.out_status == ipm_pkg::ST_READ) begin
                if (r_rd.valid) begin
                    o_entry_valid   <= 1'b1;
                    o_entry_len     <= r_rd.len;
                    o_entry_address <= r_rd.addr;
                    o_entry_country <= r_rd.cc;
                end
            end else if (i_cmd.out_status != ipm_pkg::ST_BADLEN) begin
                o_final_len     <= r_len;
                o_final_address <= r_addr;
                o_merge_count   <= r_merges;
            end
        end
    end

    assign o_out_valid = r_ovalid;

endmodule
`default_nettype wire

@@ rtl/ip_prefix_merge_table.sv @@
`default_nettype none
// channel  direction  handshake                  payload
// in       input      i_in_valid / o_in_stall    opcode address prefix_len country slot
// out      output     o_out_valid / i_out_stall  status final_* merge_count entry_*
//
// read: one table read of the given slot. insert: merges + 2 table sweeps (one fewer
// when merging reaches length zero); a sweep reads each of the TABLE_ENTRIES entries at
// most once, shorter on a hit, one entry per cycle through the single read port.
// after reset a clearing pass writes every table entry while o_in_stall is high.
// one word is handled at a time; o_in_stall is high until its result is registered.
// a stalled result holds in the output register while the next word is accepted.
module ip_prefix_merge_table (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_in_valid,
    output logic                               o_in_stall,
    input  wire                                i_opcode,
    input  wire [ipm_pkg::ADR_W-1:0]           i_address,
    input  wire [ipm_pkg::LEN_W-1:0]           i_prefix_len,
    input  wire [ipm_pkg::CC_W-1:0]            i_country,
    input  wire [ipm_pkg::IDX_W-1:0]           i_slot,
    output logic                               o_out_valid,
    input  wire                                i_out_stall,
    output logic [ipm_pkg::ST_W-1:0]           o_status,
    output logic [ipm_pkg::LEN_W-1:0]          o_final_len,
    output logic [ipm_pkg::ADR_W-1:0]          o_final_address,
    output logic [ipm_pkg::MRG_W-1:0]          o_merge_count,
    output logic                               o_entry_valid,
    output logic [ipm_pkg::LEN_W-1:0]          o_entry_len,
    output logic [ipm_pkg::ADR_W-1:0]          o_entry_address,
    output logic [ipm_pkg::CC_W-1:0]           o_entry_country
);

    ipm_pkg::t_cmd  cmd;
    ipm_pkg::t_stat stat;

    // sequencer
    ipm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // table and compare datapath
    ipm_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_opcode        (i_opcode),
        .i_address       (i_address),
        .i_prefix_len    (i_prefix_len),
        .i_country       (i_country),
        .i_slot          (i_slot),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_status        (o_status),
        .o_final_len     (o_final_len),
        .o_final_address (o_final_address),
        .o_merge_count   (o_merge_count),
        .o_entry_valid   (o_entry_valid),
        .o_entry_len     (o_entry_len),
        .o_entry_address (o_entry_address),
        .o_entry_country (o_entry_country)
    );

`ifndef NO_ASSERTIONS
    // a result is loaded only when the output register can take it
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> stat.out_free) else $error("result overwrote pending word");

    // a merge write never coincides with a store or clearing write
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.merge && (cmd.store || cmd.clear_wr))) else $error("write port conflict");

    // a merge only follows a sibling hit of the same country
    a_merge_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.merge |-> (stat.hit && stat.same)) else $error("merge without sibling");
`endif

endmodule
`default_nettype wire

@@ dv/ip_prefix_merge_table_test.sv @@
`default_nettype none
module ip_prefix_merge_table_test;
    timeunit 1ns;
    timeprecision 1ps;
    import ipm_pkg::*;

    typedef struct {
        logic [ST_W-1:0]  status;
        logic [LEN_W-1:0] final_len;
        logic [ADR_W-1:0] final_address;
        logic [MRG_W-1:0] merge_count;
        logic             entry_valid;
        logic [LEN_W-1:0] entry_len;
        logic [ADR_W-1:0] entry_address;
        logic [CC_W-1:0]  entry_country;
    } t_result;

    typedef struct {
        logic             op;
        logic [ADR_W-1:0] addr;
        logic [LEN_W-1:0] len;
        logic [CC_W-1:0]  cc;
        logic [IDX_W-1:0] slot;
        bit               typed;
        t_result          res;
    } t_row;

    localparam logic [CC_W-1:0] CC_US = 16'h5553;
    localparam logic [CC_W-1:0] CC_DE = 16'h4445;
    localparam logic [CC_W-1:0] CC_FR = 16'h4652;
    localparam longint CYCLE_LIMIT = 200_000_000;
    localparam t_result NO_RESULT = '{default: '0};

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_stall;
    logic             i_opcode;
    logic [ADR_W-1:0] i_address;
    logic [LEN_W-1:0] i_prefix_len;
    logic [CC_W-1:0]  i_country;
    logic [IDX_W-1:0] i_slot;
    logic             o_out_valid;
    logic             i_out_stall;
    logic [ST_W-1:0]  o_status;
    logic [LEN_W-1:0] o_final_len;
    logic [ADR_W-1:0] o_final_address;
    logic [MRG_W-1:0] o_merge_count;
    logic             o_entry_valid;
    logic [LEN_W-1:0] o_entry_len;
    logic [ADR_W-1:0] o_entry_address;
    logic [CC_W-1:0]  o_entry_country;

    ip_prefix_merge_table dut (.*);

    // shadow copy of the prefix table
    bit               tbl_valid [TABLE_ENTRIES];
    logic [LEN_W-1:0] tbl_len   [TABLE_ENTRIES];
    logic [ADR_W-1:0] tbl_addr  [TABLE_ENTRIES];
    logic [CC_W-1:0]  tbl_cc    [TABLE_ENTRIES];
    int               tbl_used;

    t_result pending_words[$];
    int      mismatches;
    bit      calm;
    longint  cycles;

    function automatic int find_prefix(logic [LEN_W-1:0] len, logic [ADR_W-1:0] addr);
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (tbl_valid[i] && tbl_len[i] == len && tbl_addr[i] == addr) return i;
        return -1;
    endfunction

    // expected result of one word, updating the shadow table
    function automatic t_result merge_insert_or_read(logic op, logic [ADR_W-1:0] addr,
                                                     logic [LEN_W-1:0] len,
                                                     logic [CC_W-1:0] cc,
                                                     logic [IDX_W-1:0] slot);
        t_result r;
        logic [ADR_W-1:0] bitv;
        int sib;
        int pos;
        r = NO_RESULT;
        if (op == OP_READ) begin
            r.status = ST_READ;
            if (tbl_valid[slot]) begin
                r.entry_valid   = 1'b1;
                r.entry_len     = tbl_len[slot];
                r.entry_address = tbl_addr[slot];
                r.entry_country = tbl_cc[slot];
            end
            return r;
        end
        if (len > ADR_W) begin
            r.status = ST_BADLEN;
            return r;
        end
        addr = (len == 0) ? '0 : addr & (32'hFFFF_FFFF << (ADR_W - len));
        // cascade sibling merges
        while (len > 0) begin
            bitv = 32'h1 << (ADR_W - len);
            sib = find_prefix(len, addr ^ bitv);
            if (sib < 0 || tbl_cc[sib] != cc) break;
            tbl_valid[sib] = 0;
            tbl_used--;
            addr &= ~bitv;
            len--;
            r.merge_count++;
        end
        pos = find_prefix(len, addr);
        if (pos >= 0) begin
            r.status = (tbl_cc[pos] == cc) ? ST_PRESENT : ST_CONFL;
        end else begin
            pos = -1;
            for (int i = 0; i < TABLE_ENTRIES; i++)
                if (!tbl_valid[i]) begin
                    pos = i;
                    break;
                end
            if (pos < 0) begin
                r.status = ST_FULL;
            end else begin
                tbl_valid[pos] = 1;
                tbl_len[pos]   = len;
                tbl_addr[pos]  = addr;
                tbl_cc[pos]    = cc;
                tbl_used++;
                r.status = ST_NEW;
            end
        end
        r.final_len     = len;
        r.final_address = addr;
        return r;
    endfunction

    // clock
    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // cycle limit
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver stalls
    always @(posedge i_clk) begin
        i_out_stall <= calm ? 1'b0 : ($urandom_range(99) < 37);
    end

    // result checker
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word, status %0d", o_status);
            end else begin
                e = pending_words.pop_front();
                if (o_status !== e.status || o_final_len !== e.final_len ||
                    o_final_address !== e.final_address || o_merge_count !== e.merge_count ||
                    o_entry_valid !== e.entry_valid || o_entry_len !== e.entry_len ||
                    o_entry_address !== e.entry_address ||
                    o_entry_country !== e.entry_country) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch exp st%0d len%0d a%h m%0d v%0d l%0d a%h c%h",
                                 e.status, e.final_len, e.final_address, e.merge_count,
                                 e.entry_valid, e.entry_len, e.entry_address,
                                 e.entry_country);
                        $display("         got st%0d len%0d a%h m%0d v%0d l%0d a%h c%h",
                                 o_status, o_final_len, o_final_address, o_merge_count,
                                 o_entry_valid, o_entry_len, o_entry_address,
                                 o_entry_country);
                    end
                end
            end
        end
    end

    // drive one word and wait for it to be taken
    task automatic send_word(logic op, logic [ADR_W-1:0] addr, logic [LEN_W-1:0] len,
                             logic [CC_W-1:0] cc, logic [IDX_W-1:0] slot, bit typed,
                             t_result typed_res);
        t_result r;
        while (!calm && $urandom_range(99) < 37) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_opcode     <= op;
        i_address    <= addr;
        i_prefix_len <= len;
        i_country    <= cc;
        i_slot       <= slot;
        do @(posedge i_clk); while (o_in_stall);
        r = merge_insert_or_read(op, addr, len, cc, slot);
        pending_words.insert(pending_words.size(), typed ? typed_res : r);
    endtask

    t_row directed[$];

    function automatic void add_row(t_row x);
        directed.insert(directed.size(), x);
    endfunction

    function automatic t_row row(logic op, logic [31:0] addr, logic [5:0] len,
                                 logic [15:0] cc, logic [9:0] slot);
        t_row x;
        x = '{op: op, addr: addr, len: len, cc: cc, slot: slot, typed: 0, res: NO_RESULT};
        return x;
    endfunction

    function automatic t_row typed_row(t_row x, logic [ST_W-1:0] st);
        x.typed = 1;
        x.res.status = st;
        return x;
    endfunction

    initial begin
        logic [ADR_W-1:0] a;
        logic [LEN_W-1:0] l;
        logic [CC_W-1:0]  c;
        int               n;
        mismatches = 0;
        calm = 0;
        tbl_used = 0;
        foreach (tbl_valid[i]) tbl_valid[i] = 0;
        i_rst_n = 0; i_in_valid = 0; i_opcode = 0; i_address = '0;
        i_prefix_len = '0; i_country = '0; i_slot = '0; i_out_stall = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed words
        add_row(typed_row(row(OP_READ, 0, 0, 0, 0), ST_READ));
        add_row(typed_row(row(OP_READ, '1, '1, '1, 10'd1023), ST_READ));
        add_row(typed_row(row(OP_INSERT, 32'h0A00_0000, 6'd33, CC_US, 0), ST_BADLEN));
        add_row(typed_row(row(OP_INSERT, '1, 6'd63, '1, '1), ST_BADLEN));
        add_row(row(OP_INSERT, 32'h0A00_0055, 24, CC_US, 0));
        add_row(row(OP_INSERT, 32'h0A00_01FF, 24, CC_US, 0));
        add_row(row(OP_INSERT, 32'h0A00_0200, 23, CC_US, 0));
        add_row(row(OP_INSERT, 32'h0A00_0123, 22, CC_US, 0));
        add_row(row(OP_INSERT, 32'h0A00_0000, 22, CC_DE, 0));
        add_row(row(OP_INSERT, 32'h0A00_0400, 22, CC_DE, 0));
        add_row(row(OP_INSERT, '1, 32, '1, 0));
        add_row(row(OP_INSERT, 32'hFFFF_FFFE, 32, '1, 0));
        add_row(row(OP_INSERT, 32'h1234_5678, 0, CC_FR, 0));
        add_row(row(OP_INSERT, 32'h8000_0000, 1, CC_FR, 0));
        add_row(row(OP_INSERT, 32'h0000_0001, 1, CC_FR, 0));
        add_row(row(OP_INSERT, 32'h0000_0000, 32, 16'h0000, 0));
        add_row(row(OP_READ, 0, 0, 0, 0));
        add_row(row(OP_READ, 0, 0, 0, 1));
        add_row(row(OP_READ, 0, 0, 0, 2));
        add_row(row(OP_READ, 0, 0, 0, 3));
        add_row(row(OP_READ, 0, 0, 0, 4));
        foreach (directed[i])
            send_word(directed[i].op, directed[i].addr, directed[i].len, directed[i].cc,
                      directed[i].slot, directed[i].typed, directed[i].res);

        // random words: reads, clustered prefixes that merge, other inserts and bad lengths
        for (int k = 0; k < 670; k++) begin
            calm = (k >= 250 && k < 370);
            n = $urandom_range(99);
            c = ($urandom_range(3) == 0) ? CC_DE : CC_US;
            if (n < 40) begin
                send_word(OP_READ, $urandom, LEN_W'($urandom), CC_W'($urandom),
                          ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(63)),
                          0, NO_RESULT);
            end else if (n < 85) begin
                l = 6'($urandom_range(32, 24));
                a = {8'h0A, 6'd0, 2'($urandom_range(3)), 16'($urandom)};
                send_word(OP_INSERT, a, l, c, IDX_W'($urandom), 0, NO_RESULT);
            end else if (n < 95) begin
                send_word(OP_INSERT, $urandom, 6'($urandom_range(32)), CC_W'($urandom),
                          IDX_W'($urandom), 0, NO_RESULT);
            end else begin
                send_word(OP_INSERT, $urandom, 6'($urandom_range(63, 33)), CC_W'($urandom),
                          IDX_W'($urandom), 0, NO_RESULT);
            end
        end
        calm = 0;

        // fill the table to overflow with unmergeable host routes
        n = 0;
        while (tbl_used < TABLE_ENTRIES || n < 1030) begin
            send_word(OP_INSERT, 32'hC000_0000 + 32'(2 * n), 32, CC_FR, 0, 0, NO_RESULT);
            n++;
            if (n % 8 == 0)
                send_word(OP_READ, 0, 0, 0, 10'($urandom), 0, NO_RESULT);
        end
        // full table still accepts a merge
        send_word(OP_INSERT, 32'hC000_0001, 32, CC_FR, 0, 0, NO_RESULT);
        send_word(OP_INSERT, 32'h0B00_0000, 8, CC_FR, 0, 0, NO_RESULT);
        send_word(OP_READ, 0, 0, 0, 10'd1023, 0, NO_RESULT);

        i_in_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

@@ ip_prefix_merge_table.f @@
rtl/ipm_pkg.sv
rtl/ipm_ctrl.sv
rtl/ipm_dp.sv
rtl/ip_prefix_merge_table.sv
dv/ip_prefix_merge_table_test.sv
